### design/tdts_pkg.sv
// ----------------------------------------------------------------------------
// tdts_pkg
// Shared beat types and sequencer states for the tick/delay task scheduler.
// ----------------------------------------------------------------------------
package tdts_pkg;

	localparam logic CMD_TICK  = 1'b0;
	localparam logic CMD_DELAY = 1'b1;

	typedef struct packed {
		logic        cmd;
		logic [31:0] delay_ticks;
	} item_t;

	typedef struct packed {
		logic [2:0]  running_task;
		logic [7:0]  ready_mask;
		logic [31:0] tick_now;
	} result_t;

	// Core to top: handshake status of the sequencer.
	typedef struct packed {
		logic busy;
		logic done;
	} core_status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FLUSH,
		ST_PICK,
		ST_DONE
	} seq_state_t;

endpackage

### design/tick_delay_task_scheduler_unit.sv
// ----------------------------------------------------------------------------
// tick_delay_task_scheduler_unit
// Fixed-priority task scheduler driven by timer ticks and delay requests.
// ----------------------------------------------------------------------------
//
//  channel | valid     | stall     | beat                       | dir
//  --------+-----------+-----------+----------------------------+-----
//  command | cmd_valid | cmd_stall | cmd_beat (item_t)          | in
//  result  | res_valid | res_stall | res_beat (result_t)        | out
//
//  Tick beat: the sequencer sweeps the wake-time memory in ST_SCAN (one read
//  per task 1..TASK_COUNT-1, one read port), then steps through ST_FLUSH (last
//  compare), ST_PICK (select) and ST_DONE (present), then res_valid rises.
//  Delay beat: wake time written at the accepting edge, then ST_PICK (select)
//  and ST_DONE (present); a delay while task 0 (idle) runs goes to ST_DONE.
//  ST_DONE holds until the output register is free. The next command can be taken in the cycle after the result loads.
//  One command is processed at a time; cmd_stall is high while it runs.
//  The result register is separate, so a new command is taken while a result
//  still waits on res_stall. Reset: all tasks ready, tick 0, task 1 running.
//  The wake table needs no clearing: an entry is only used while its task
//  is blocked, which happens only after a delay has written it.
// ----------------------------------------------------------------------------
module tick_delay_task_scheduler_unit #(
	parameter int TASK_COUNT = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	output logic              cmd_stall,
	input  tdts_pkg::item_t   cmd_beat,
	output logic              res_valid,
	input  logic              res_stall,
	output tdts_pkg::result_t res_beat
);
	import tdts_pkg::*;

	core_status_t status;
	result_t      core_result;
	logic         start;
	logic         take;
	logic         res_valid_q;
	result_t      res_q;

	// command accepted only while the sequencer is idle
	assign cmd_stall = status.busy;
	assign start     = cmd_valid && !cmd_stall;

	// output register is free when empty or being drained this cycle
	assign take = !res_valid_q || !res_stall;

	tdts_core #(
		.TASK_COUNT (TASK_COUNT)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.item   (cmd_beat),
		.take   (take),
		.status (status),
		.result (core_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (status.done && take) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (status.done && take) begin
			res_q <= core_result;
		end
	end

	assign res_valid = res_valid_q;
	assign res_beat  = res_q;

endmodule

### design/tdts_wake_mem.sv
// ----------------------------------------------------------------------------
// tdts_wake_mem
// Wake-time table: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tdts_wake_mem #(
	parameter int DEPTH = 8,
	parameter int AW    = 3
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [31:0]   wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [31:0]   rdata
);

	logic [31:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### design/tdts_core.sv
// ----------------------------------------------------------------------------
// tdts_core
// Scheduler sequencer: tick counter, ready bits, wake-table sweep, selection.
// ----------------------------------------------------------------------------
module tdts_core #(
	parameter int TASK_COUNT = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  tdts_pkg::item_t       item,
	input  logic                  take,
	output tdts_pkg::core_status_t status,
	output tdts_pkg::result_t     result
);
	import tdts_pkg::*;

	localparam int IDX_W = $clog2(TASK_COUNT);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TASK_COUNT - 1);

	seq_state_t state_q, state_d;

	logic [31:0]           tick_q;
	logic [TASK_COUNT-1:0] ready_q;
	logic [IDX_W-1:0]      cur_q;
	logic [IDX_W-1:0]      idx_q;
	logic                  chk_vld_s1;
	logic [IDX_W-1:0]      chk_idx_s1;

	logic                  mem_we;
	logic                  mem_re;
	logic [31:0]           mem_wdata;
	logic [31:0]           mem_rdata;
	logic [IDX_W-1:0]      pick;
	logic                  do_delay;
	logic [IDX_W+2:0]      idx_ext;
	logic [TASK_COUNT+7:0] mask_ext;

	tdts_wake_mem #(
		.DEPTH (TASK_COUNT),
		.AW    (IDX_W)
	) u_wake_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (cur_q),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (idx_q),
		.rdata (mem_rdata)
	);

	// delay is honored only while a real task runs
	assign do_delay  = start && (item.cmd == CMD_DELAY) && (cur_q != '0);
	assign mem_we    = do_delay;
	assign mem_wdata = tick_q + item.delay_ticks;
	assign mem_re    = (state_q == ST_SCAN);

	// lowest ready task from 1 upward, idle 0 otherwise
	always_comb begin
		pick = '0;
		for (int i = TASK_COUNT - 1; i >= 1; i--) begin
			if (ready_q[i]) begin
				pick = IDX_W'(i);
			end
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					if (item.cmd == CMD_TICK) begin
						state_d = ST_SCAN;
					end else if (do_delay) begin
						state_d = ST_PICK;
					end else begin
						state_d = ST_DONE;
					end
				end
			end
			ST_SCAN: begin
				if (idx_q == LAST_IDX) begin
					state_d = ST_FLUSH;
				end
			end
			ST_FLUSH: state_d = ST_PICK;
			ST_PICK:  state_d = ST_DONE;
			ST_DONE: begin
				if (take) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		status.busy = (state_q != ST_IDLE);
		status.done = (state_q == ST_DONE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			tick_q     <= '0;
			ready_q    <= '1;
			cur_q      <= IDX_W'(1);
			idx_q      <= IDX_W'(1);
			chk_vld_s1 <= 1'b0;
			chk_idx_s1 <= '0;
		end else begin
			state_q    <= state_d;
			chk_vld_s1 <= mem_re;
			chk_idx_s1 <= idx_q;
			if (state_q == ST_IDLE) begin
				idx_q <= IDX_W'(1);
				if (start && item.cmd == CMD_TICK) begin
					tick_q <= tick_q + 32'd1;
				end
			end else if (state_q == ST_SCAN) begin
				idx_q <= idx_q + IDX_W'(1);
			end
			// wake check lands in the cycle after the read
			if (chk_vld_s1 && !ready_q[chk_idx_s1] && mem_rdata == tick_q) begin
				ready_q[chk_idx_s1] <= 1'b1;
			end
			if (do_delay) begin
				ready_q[cur_q] <= 1'b0;
			end
			if (state_q == ST_PICK) begin
				cur_q <= pick;
			end
		end
	end

	// narrow or widen to the fixed result fields
	assign idx_ext  = {3'b000, cur_q};
	assign mask_ext = {8'h00, ready_q};

	always_comb begin
		result.running_task = idx_ext[2:0];
		result.ready_mask   = mask_ext[7:0];
		result.tick_now     = tick_q;
	end

endmodule

### test/tick_delay_task_scheduler_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tick_delay_task_scheduler_unit_test
// Self-checking bench for the tick/delay task scheduler. A scoreboard class
// tracks the task table and predicts the result beat of every accepted
// command. Plain tasks drive directed and random command streams while both
// channels idle and stall at random.
// ----------------------------------------------------------------------------
module tick_delay_task_scheduler_unit_test;
	import tdts_pkg::*;

	class sched_tracker #(parameter int TASKS = 8);
		bit          ready   [TASKS];
		logic [31:0] wake_at [TASKS];
		logic [31:0] ticks;
		int unsigned current;
		result_t     expected_picks[$];
		int          mismatches;

		function new();
			for (int i = 0; i < TASKS; i++) begin
				ready[i]   = 1'b1;
				wake_at[i] = '0;
			end
			ticks      = '0;
			current    = 1;
			mismatches = 0;
		endfunction

		// lowest ready task above idle wins
		function void select_next_task();
			current = 0;
			for (int i = TASKS - 1; i >= 1; i--)
				if (ready[i]) current = i;
		endfunction

		function logic [7:0] ready_bits();
			logic [7:0] m;
			m = '0;
			for (int i = 0; i < TASKS && i < 8; i++) m[i] = ready[i];
			return m;
		endfunction

		function void flag(string what);
			mismatches++;
			if (mismatches <= 10) $display("[%0t] mismatch: %s", $time, what);
		endfunction

		function void log_command(item_t beat);
			result_t pick;
			if (beat.cmd == CMD_TICK) begin
				ticks = ticks + 32'd1;
				for (int i = 1; i < TASKS; i++)
					if (!ready[i] && wake_at[i] == ticks) ready[i] = 1'b1;
				select_next_task();
			end else if (current != 0) begin
				wake_at[current] = ticks + beat.delay_ticks;
				ready[current]   = 1'b0;
				select_next_task();
			end
			pick.running_task = 3'(current);
			pick.ready_mask   = ready_bits();
			pick.tick_now     = ticks;
			expected_picks.push_back(pick);
		endfunction

		function void check_beat(result_t got);
			result_t want;
			if (expected_picks.size() == 0) begin
				flag($sformatf("result beat %p with nothing outstanding", got));
				return;
			end
			want = expected_picks.pop_front();
			if (got.running_task !== want.running_task)
				flag($sformatf("running_task expected %0d got %0d",
					want.running_task, got.running_task));
			if (got.ready_mask !== want.ready_mask)
				flag($sformatf("ready_mask expected %b got %b",
					want.ready_mask, got.ready_mask));
			if (got.tick_now !== want.tick_now)
				flag($sformatf("tick_now expected %0h got %0h",
					want.tick_now, got.tick_now));
		endfunction

		function int pending();
			return expected_picks.size();
		endfunction
	endclass

	localparam int TASKS       = 8;
	localparam int IDLE_LIMIT  = 5000;	// cycles with no beat on either channel
	localparam int PHASE_BEATS = 206;	// counted commands per random phase

	logic    clk;
	logic    arst_n    = 1'b0;
	logic    cmd_valid = 1'b0;
	logic    cmd_stall;
	item_t   cmd_beat  = '0;
	logic    res_valid;
	logic    res_stall = 1'b0;
	result_t res_beat;

	// per-cycle odds (percent) of a sender gap and of a receiver stall
	int cmd_idle_pct  = 0;
	int res_stall_pct = 0;
	int quiet_cycles  = 0;

	sched_tracker #(TASKS) tracker;

	tick_delay_task_scheduler_unit #(.TASK_COUNT(TASKS)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd_beat (cmd_beat),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res_beat (res_beat)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Receiver: random back-pressure, odds set per phase.
	always @(posedge clk) begin
		res_stall <= ($urandom_range(99) < res_stall_pct);
	end

	// Result side: every accepted beat is checked against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall) tracker.check_beat(res_beat);
	end

	// Watchdog: a long stretch with no beat on either channel means a hang.
	always @(posedge clk) begin
		if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= IDLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// Send one command beat. An optional gap comes first; valid stays high from
	// one beat to the next when there is no gap. The prediction is logged right
	// at the accepting edge, so callers see the updated task table on return.
	task automatic push_cmd(input logic op, input logic [31:0] span);
		item_t beat;
		beat.cmd         = op;
		beat.delay_ticks = span;
		if (cmd_idle_pct > 0 && $urandom_range(99) < cmd_idle_pct) begin
			cmd_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < cmd_idle_pct);
		end
		cmd_valid <= 1'b1;
		cmd_beat  <= beat;
		do @(posedge clk); while (cmd_stall);
		tracker.log_command(beat);
	endtask

	// Hold off the command side until every predicted result has come back.
	task automatic wait_drained();
		cmd_valid <= 1'b0;
		@(posedge clk);
		while (tracker.pending() != 0) @(posedge clk);
	endtask

	initial begin
		int          done_beats;
		logic [31:0] span;
		int          naps [7];

		naps    = '{1, 3, 2, 5, 4, 1, 6};
		tracker = new();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// ---- directed --------------------------------------------------------
		// Ticks ignore the delay field; both extremes of it ride along.
		push_cmd(CMD_TICK, 32'h0000_0000);
		push_cmd(CMD_TICK, 32'hFFFF_FFFF);
		// Put every task to sleep in priority order, down to task 7, which
		// leaves only idle running. Tasks 1 and 6 share a wake tick.
		foreach (naps[i]) push_cmd(CMD_DELAY, naps[i]);
		// Delay while idle: nothing changes.
		push_cmd(CMD_DELAY, 32'hFFFF_FFFF);
		push_cmd(CMD_DELAY, 32'h0000_0000);
		// Tick through the wake times; tasks come back one or two at a time.
		repeat (6) push_cmd(CMD_TICK, $urandom());

		// ---- random ----------------------------------------------------------
		// Short naps keep tasks cycling between ready and blocked; longer ones
		// let several sleepers pile up and wake on the same tick. Zero and huge
		// delays park a task for good, so they are held back for the very end.
		for (int blk = 0; blk < 8; blk++) begin
			case (blk % 4)
				0: begin
					cmd_idle_pct  = 0;
					res_stall_pct = 0;
				end
				1: begin
					cmd_idle_pct  = 76;
					res_stall_pct = 0;
				end
				2: begin
					cmd_idle_pct  = 0;
					res_stall_pct = 76;
				end
				default: begin
					cmd_idle_pct  = 19;
					res_stall_pct = 19;
				end
			endcase
			done_beats = 0;
			while (done_beats < PHASE_BEATS) begin
				if (tracker.current == 0 && $urandom_range(9) == 0) begin
					// delay while idle; ignored, so not counted
					push_cmd(CMD_DELAY, $urandom());
				end else begin
					if (tracker.current != 0 && $urandom_range(99) < 45) begin
						span = ($urandom_range(3) == 0) ? $urandom_range(40, 9)
							: $urandom_range(8, 1);
						push_cmd(CMD_DELAY, span);
					end else begin
						push_cmd(CMD_TICK, $urandom());
					end
					done_beats++;
				end
			end
			wait_drained();
		end

		// ---- parking delays --------------------------------------------------
		// A zero delay blocks until the counter wraps, and a delay of all ones
		// lands one tick behind now; neither task comes back in this run.
		cmd_idle_pct  = 19;
		res_stall_pct = 19;
		while (tracker.current == 0) push_cmd(CMD_TICK, $urandom());
		push_cmd(CMD_DELAY, 32'h0000_0000);
		while (tracker.current == 0) push_cmd(CMD_TICK, $urandom());
		push_cmd(CMD_DELAY, 32'hFFFF_FFFF);
		// Park the rest with large random delays until only idle is left.
		for (int k = 0; k < 60; k++) begin
			if (tracker.current != 0)
				push_cmd(CMD_DELAY, $urandom() | 32'h8000_0000);
			else
				push_cmd(CMD_TICK, $urandom());
		end
		repeat (3) push_cmd(CMD_DELAY, $urandom());

		// ---- wrap up ---------------------------------------------------------
		wait_drained();
		repeat (TASKS + 8) @(posedge clk);
		if (tracker.mismatches == 0 && tracker.pending() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule
